FILE: design/radiotap_pcapng_capture_framer_assert.svh
// Assertion macros for the radiotap pcapng capture framer.
`ifndef RADIOTAP_PCAPNG_CAPTURE_FRAMER_ASSERT_SVH
`define RADIOTAP_PCAPNG_CAPTURE_FRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPCF_ASSERT_IMPL(name, c, r, pre, post) \
  name: assert property (@(posedge c) disable iff (!r) (pre) |-> (post)) \
    else $error("rpcf assertion failed");
`define RPCF_ASSERT_NEXT(name, c, r, pre, post) \
  name: assert property (@(posedge c) disable iff (!r) (pre) |=> (post)) \
    else $error("rpcf assertion failed");
`else
`define RPCF_ASSERT_IMPL(name, c, r, pre, post)
`define RPCF_ASSERT_NEXT(name, c, r, pre, post)
`endif
`endif

FILE: design/rpcf_pkg.sv
// Types and constants shared by the capture framer modules.
`default_nettype none
package rpcf_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_HEADER = 2'd1,
    OP_DATA   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_HEADER  = 2'd1,
    CMD_DATA    = 2'd2,
    CMD_LAST    = 2'd3
  } cmd_kind_t;

  localparam int LEN_W  = 12;
  localparam int BTL_W  = 13;
  localparam int FREQ_W = 12;
  localparam int IDX_W  = 6;

  localparam logic [15:0]       SNAP_RESET      = 16'd2048;
  localparam logic [LEN_W-1:0]  LEN_DEFAULT     = 12'd2048;
  localparam logic [LEN_W-1:0]  LEN_MGMT        = 12'd24;
  localparam logic [BTL_W-1:0]  EPB_FIXED_LEN   = 13'd52;
  localparam logic [BTL_W-1:0]  RT_LEN          = 13'd16;
  localparam logic [FREQ_W-1:0] FREQ_BASE       = 12'd2407;
  localparam logic [FREQ_W-1:0] FREQ_CH14       = 12'd2484;
  localparam logic [FREQ_W-1:0] FREQ_DEFAULT    = 12'd2412;
  localparam logic [7:0]        FLAGS_2GHZ      = 8'h80;
  localparam logic [7:0]        FLAGS_2GHZ_CH14 = 8'h90;

  localparam logic [IDX_W-1:0] CAP_SHB_END  = 6'd27;
  localparam logic [IDX_W-1:0] CAP_IDB_END  = 6'd59;
  localparam logic [IDX_W-1:0] HDR_END      = 6'd43;
  localparam logic [IDX_W-1:0] LAST_TAIL    = 6'd8;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data_byte;
    logic [15:0]        snap;
    logic [BTL_W-1:0]   btl;
    logic [BTL_W-1:0]   caplen;
    logic [BTL_W-1:0]   origlen;
    logic [FREQ_W-1:0]  freq;
    logic [7:0]         flags;
    logic [7:0]         rssi;
    logic [63:0]        ts_us;
    logic [1:0]         pad;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       block_end;
  } out_word_t;

endpackage
`default_nettype wire

FILE: design/radiotap_pcapng_capture_framer.sv
// Top level of the radiotap pcapng capture framer.
//
//  channel  | handshake            | words
//  ---------+----------------------+-------------------------------------------
//  in_      | in_push / in_full    | op, lengths, channels, rssi, time, byte
//  out_     | out_pop / out_empty  | out_byte, out_block_end
//  cfg_     | cfg_wr_en            | cfg_snap_length
//
// One input word per cycle while the command queue (CMD_DEPTH) has room; in_full is its full.
// The serializer writes one byte per cycle while the output queue (OUT_DEPTH) has room: 60 for
// a capture start, 44 for a frame header, 1 per payload byte, 9 to 12 on the last captured byte.
// Behind a 60- or 44-byte burst the input stalls once CMD_DEPTH commands wait; a word's first
// byte passes the command queue and then the output queue on its way to the result ports.
// Synchronous reset clears the queues and frame state; snap length returns to 2048.
`default_nettype none
`include "radiotap_pcapng_capture_framer_assert.svh"
module radiotap_pcapng_capture_framer #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_snap_length,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_op,
  input  logic [11:0]       in_signal_length,
  input  logic              in_is_management,
  input  logic [3:0]        in_rx_channel,
  input  logic [3:0]        in_tuned_channel,
  input  logic signed [7:0] in_rssi_dbm,
  input  logic [63:0]       in_timestamp_us,
  input  logic [7:0]        in_data_byte,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_byte,
  output logic              out_block_end
);
  import rpcf_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int OUT_W = $bits(out_word_t);

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_in, cmd_head;
  logic      out_push, out_full;
  out_word_t out_in, out_head;
  logic      end_kind_ok;

  rpcf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_snap_length  (cfg_snap_length),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_op            (in_op),
    .in_signal_length (in_signal_length),
    .in_is_management (in_is_management),
    .in_rx_channel    (in_rx_channel),
    .in_tuned_channel (in_tuned_channel),
    .in_rssi_dbm      (in_rssi_dbm),
    .in_timestamp_us  (in_timestamp_us),
    .in_data_byte     (in_data_byte),
    .cmd_push         (cmd_push),
    .cmd_word         (cmd_in),
    .cmd_full         (cmd_full)
  );

  rpcf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  rpcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_word  (out_in)
  );

  rpcf_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (out_in),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_head),
    .empty   (out_empty)
  );

  assign out_byte      = out_head.out_byte;
  assign out_block_end = out_head.block_end;

  assign end_kind_ok = (cmd_head.kind == CMD_CAPTURE) || (cmd_head.kind == CMD_LAST);

  `RPCF_ASSERT_IMPL(a_out_no_overflow, clk, rst_n, out_push, !out_full)
  `RPCF_ASSERT_IMPL(a_cmd_pop_nonempty, clk, rst_n, cmd_pop, !cmd_empty)
  `RPCF_ASSERT_IMPL(a_end_kind, clk, rst_n, out_push && out_in.block_end, end_kind_ok)
  `RPCF_ASSERT_NEXT(a_push_fills, clk, rst_n, out_push, !out_empty)

endmodule
`default_nettype wire

FILE: design/rpcf_fifo.sv
// Small register queue with push/full and pop/empty sides.
`default_nettype none
module rpcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/rpcf_front.sv
// Front end: accepts input words, tracks frame state, queues byte-stream commands.
`default_nettype none
module rpcf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_snap_length,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [1:0]                in_op,
  input  logic [11:0]               in_signal_length,
  input  logic                      in_is_management,
  input  logic [3:0]                in_rx_channel,
  input  logic [3:0]                in_tuned_channel,
  input  logic signed [7:0]         in_rssi_dbm,
  input  logic [63:0]               in_timestamp_us,
  input  logic [7:0]                in_data_byte,
  output logic                      cmd_push,
  output rpcf_pkg::cmd_t            cmd_word,
  input  logic                      cmd_full
);
  import rpcf_pkg::*;

  logic [15:0]      snap_r;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             open_r, open_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [BTL_W-1:0] btl_r, btl_nxt;

  op_t              op;
  logic             accept;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] cap;
  logic [1:0]       pad_new;
  logic [BTL_W-1:0] btl_new;
  logic             rx_ok;
  logic [3:0]       ch;
  logic [FREQ_W-1:0] freq;

  assign op      = op_t'(in_op);
  assign in_full = cmd_full;
  assign accept  = in_push & ~cmd_full;

  assign len_eff = (in_signal_length == '0) ?
                   (in_is_management ? LEN_MGMT : LEN_DEFAULT) : in_signal_length;
  assign cap     = ({4'b0, len_eff} < snap_r) ? len_eff : snap_r[LEN_W-1:0];
  assign pad_new = 2'(2'd0 - cap[1:0]);
  assign btl_new = EPB_FIXED_LEN + BTL_W'(cap) + BTL_W'(pad_new);

  assign rx_ok = (in_rx_channel >= 4'd1) && (in_rx_channel <= 4'd14);
  assign ch    = rx_ok ? in_rx_channel : in_tuned_channel;

  always_comb begin
    if (ch >= 4'd1 && ch <= 4'd13) begin
      freq = FREQ_BASE + FREQ_W'(ch) * FREQ_W'(5);
    end else if (ch == 4'd14) begin
      freq = FREQ_CH14;
    end else begin
      freq = FREQ_DEFAULT;
    end
  end

  always_comb begin
    cmd_word.kind      = CMD_DATA;
    cmd_word.data_byte = in_data_byte;
    cmd_word.snap      = snap_r;
    cmd_word.btl       = (op == OP_HEADER) ? btl_new : btl_r;
    cmd_word.caplen    = RT_LEN + BTL_W'(cap);
    cmd_word.origlen   = RT_LEN + BTL_W'(len_eff);
    cmd_word.freq      = freq;
    cmd_word.flags     = (ch == 4'd14) ? FLAGS_2GHZ_CH14 : FLAGS_2GHZ;
    cmd_word.rssi      = in_rssi_dbm;
    cmd_word.ts_us     = in_timestamp_us;
    cmd_word.pad       = pad_r;
    cmd_push = 1'b0;
    left_nxt = left_r;
    open_nxt = open_r;
    pad_nxt  = pad_r;
    btl_nxt  = btl_r;
    if (accept) begin
      unique case (op)
        OP_START: begin
          cmd_push      = 1'b1;
          cmd_word.kind = CMD_CAPTURE;
          open_nxt      = 1'b0;
          left_nxt      = '0;
        end
        OP_HEADER: begin
          open_nxt = 1'b0;
          left_nxt = '0;
          if (cap != '0) begin
            cmd_push      = 1'b1;
            cmd_word.kind = CMD_HEADER;
            open_nxt      = 1'b1;
            left_nxt      = cap;
            pad_nxt       = pad_new;
            btl_nxt       = btl_new;
          end
        end
        OP_DATA: begin
          if (open_r && left_r != '0) begin
            cmd_push      = 1'b1;
            cmd_word.kind = (left_r == LEN_W'(1)) ? CMD_LAST : CMD_DATA;
            left_nxt      = left_r - LEN_W'(1);
            open_nxt      = (left_r != LEN_W'(1));
          end
        end
        OP_NONE: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_r <= SNAP_RESET;
      left_r <= '0;
      open_r <= 1'b0;
      pad_r  <= '0;
      btl_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        snap_r <= cfg_snap_length;
      end
      left_r <= left_nxt;
      open_r <= open_nxt;
      pad_r  <= pad_nxt;
      btl_r  <= btl_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/rpcf_back.sv
// Back end: serializes queued commands into pcapng stream bytes.
`default_nettype none
module rpcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  rpcf_pkg::cmd_t      cmd_word,
  output logic                cmd_pop,
  input  logic                out_full,
  output logic                out_push,
  output rpcf_pkg::out_word_t out_word
);
  import rpcf_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [63:0]      ts_a_r, ts_b_r;
  logic [IDX_W-1:0] last_idx;
  logic             act, done;
  logic [31:0]      btl32, caplen32, origlen32;
  logic [IDX_W-1:0] tail_k;
  logic [7:0]       b;
  logic             b_end;

  assign btl32     = 32'(cmd_word.btl);
  assign caplen32  = 32'(cmd_word.caplen);
  assign origlen32 = 32'(cmd_word.origlen);
  assign tail_k    = idx_r - IDX_W'(1) - IDX_W'(cmd_word.pad);

  always_comb begin
    unique case (cmd_word.kind)
      CMD_CAPTURE: last_idx = CAP_IDB_END;
      CMD_HEADER:  last_idx = HDR_END;
      CMD_DATA:    last_idx = '0;
      CMD_LAST:    last_idx = LAST_TAIL + IDX_W'(cmd_word.pad);
    endcase
  end

  assign act      = ~cmd_empty & ~out_full;
  assign done     = act & (idx_r == last_idx);
  assign cmd_pop  = done;
  assign out_push = act;
  assign idx_nxt  = done ? '0 : (act ? idx_r + IDX_W'(1) : idx_r);

  always_comb begin
    b     = 8'h00;
    b_end = 1'b0;
    unique case (cmd_word.kind)
      CMD_CAPTURE: begin
        case (idx_r)
          6'd0, 6'd3:   b = 8'h0A;
          6'd1, 6'd2:   b = 8'h0D;
          6'd4, 6'd24:  b = 8'h1C;
          6'd8:         b = 8'h4D;
          6'd9:         b = 8'h3C;
          6'd10:        b = 8'h2B;
          6'd11:        b = 8'h1A;
          6'd12:        b = 8'h01;
          6'd16, 6'd17, 6'd18, 6'd19,
          6'd20, 6'd21, 6'd22, 6'd23: b = 8'hFF;
          6'd28:        b = 8'h01;
          6'd32, 6'd56: b = 8'h20;
          6'd36:        b = 8'h7F;
          6'd40:        b = cmd_word.snap[7:0];
          6'd41:        b = cmd_word.snap[15:8];
          6'd44:        b = 8'h09;
          6'd46:        b = 8'h01;
          6'd48:        b = 8'h09;
          default:      b = 8'h00;
        endcase
        b_end = (idx_r == CAP_SHB_END) || (idx_r == CAP_IDB_END);
      end
      CMD_HEADER: begin
        case (idx_r)
          6'd0:                        b = 8'h06;
          6'd4, 6'd5, 6'd6, 6'd7:      b = btl32[8*idx_r[1:0] +: 8];
          6'd12, 6'd13, 6'd14, 6'd15:  b = ts_b_r[32 + 8*idx_r[1:0] +: 8];
          6'd16, 6'd17, 6'd18, 6'd19:  b = ts_b_r[8*idx_r[1:0] +: 8];
          6'd20, 6'd21, 6'd22, 6'd23:  b = caplen32[8*idx_r[1:0] +: 8];
          6'd24, 6'd25, 6'd26, 6'd27:  b = origlen32[8*idx_r[1:0] +: 8];
          6'd30:                       b = 8'h10;
          6'd32:                       b = 8'h28;
          6'd33:                       b = 8'h08;
          6'd36:                       b = cmd_word.freq[7:0];
          6'd37:                       b = 8'(cmd_word.freq[FREQ_W-1:8]);
          6'd38:                       b = cmd_word.flags;
          6'd40:                       b = cmd_word.rssi;
          default:                     b = 8'h00;
        endcase
      end
      CMD_DATA: begin
        b = cmd_word.data_byte;
      end
      CMD_LAST: begin
        if (idx_r == '0) begin
          b = cmd_word.data_byte;
        end else if (idx_r <= IDX_W'(cmd_word.pad) || tail_k < IDX_W'(4)) begin
          b = 8'h00;
        end else begin
          b = btl32[8*tail_k[1:0] +: 8];
        end
        b_end = (idx_r == last_idx);
      end
    endcase
  end

  assign out_word.out_byte  = b;
  assign out_word.block_end = b_end;

  // timestamp times 1000 as 1024 - 16 - 8, over the first two header bytes
  always_ff @(posedge clk) begin
    if (!cmd_empty && cmd_word.kind == CMD_HEADER) begin
      if (idx_r == '0) begin
        ts_a_r <= (cmd_word.ts_us << 10) - (cmd_word.ts_us << 4);
      end
      if (idx_r == IDX_W'(1)) begin
        ts_b_r <= ts_a_r - (cmd_word.ts_us << 3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire
